### src/dads_pkg.sv
// shared constants and types for the duration add / diff / split unit
package dads_pkg;

  // pipeline depth, input register through output register
  localparam int NUM_STAGES = 8;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_DIFF  = 2'd1,
    KIND_SPLIT = 2'd2
  } kind_e;

  // nanosecond wrap points
  localparam logic [30:0] NS_PER_SEC  = 31'd1000000000;
  localparam logic [30:0] NS_TWO_SEC  = 31'd2000000000;

  // a borrowed nanosecond difference that is still negative wraps through 2^64 ns,
  // which is 18446744073 s plus 709551616 ns
  localparam logic [30:0] NS_NEG_OFFSET = 31'd1709551616;
  localparam logic [34:0] NS_NEG_CARRY  = 35'd18446744073;

  // calendar divisors (364-day years)
  localparam logic [24:0] SEC_PER_YEAR = 25'd31449600;
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

  // exact reciprocals: shift = dividend bits + divisor bits, rounded up
  localparam int YEAR_SHIFT = 57;
  localparam int DAY_SHIFT  = 42;
  localparam int HOUR_SHIFT = 29;
  localparam int MIN_SHIFT  = 18;

  localparam logic [32:0] YEAR_RECIP = 33'(((64'd1 << YEAR_SHIFT) + 64'(SEC_PER_YEAR)
                                            - 64'd1) / 64'(SEC_PER_YEAR));
  localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_SHIFT) + 64'(SEC_PER_DAY)
                                            - 64'd1) / 64'(SEC_PER_DAY));
  localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << HOUR_SHIFT) + 64'(SEC_PER_HOUR)
                                            - 64'd1) / 64'(SEC_PER_HOUR));
  localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << MIN_SHIFT) + 64'(SEC_PER_MIN)
                                            - 64'd1) / 64'(SEC_PER_MIN));

  // add / difference result
  typedef struct packed {
    logic [31:0] seconds;
    logic [29:0] nanos;
    logic        overflow;
  } arith_res_t;

  // split result
  typedef struct packed {
    logic [7:0] years;
    logic [8:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } split_res_t;

endpackage

### src/dads_arith.sv
// add and absolute difference pipeline for seconds plus nanoseconds
module dads_arith import dads_pkg::*; #(
  parameter int SEC_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] stage_en_i,
  input  logic [1:0]            kind_i,
  input  logic [31:0]           a_seconds_i,
  input  logic [29:0]           a_nanos_i,
  input  logic [31:0]           b_seconds_i,
  input  logic [29:0]           b_nanos_i,
  output arith_res_t            res_o
);

  localparam logic [63:0] SEC_MAX = (64'd1 << SEC_WIDTH) - 64'd1;
  localparam logic [31:0] IN_MASK = SEC_MAX[31:0];
  localparam int          LAST    = NUM_STAGES - 1;

  // stage 0: order the operands
  logic [31:0] a_s, b_s;
  logic        a_first, is_diff, is_mine, swap;

  assign a_s     = a_seconds_i & IN_MASK;
  assign b_s     = b_seconds_i & IN_MASK;
  assign a_first = (a_s > b_s) || ((a_s == b_s) && (a_nanos_i > b_nanos_i));
  assign is_diff = (kind_i == KIND_DIFF);
  assign is_mine = (kind_i == KIND_ADD) || (kind_i == KIND_DIFF);
  assign swap    = is_diff && !a_first;

  logic [LAST-1:0] mine_q;
  logic            diff0_q;
  logic [31:0]     hs0_q, ls0_q;
  logic [29:0]     hn0_q, ln0_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      diff0_q <= is_diff;
      hs0_q   <= swap ? b_s : a_s;
      hn0_q   <= swap ? b_nanos_i : a_nanos_i;
      ls0_q   <= swap ? a_s : b_s;
      ln0_q   <= swap ? a_nanos_i : b_nanos_i;
    end
  end

  // stage 1: raw sum or borrowed difference
  logic        borrow, ns_neg;
  logic [30:0] ns_ofs;
  logic [30:0] ns1_d, ns1_q;
  logic [33:0] sec1_d, sec1_q;
  logic        neg1_q;

  assign borrow = diff0_q && (hn0_q < ln0_q);
  // borrowed difference still below zero when the low side exceeds by over a second
  assign ns_neg = borrow && (31'(ln0_q) > 31'(hn0_q) + NS_PER_SEC);
  assign ns_ofs = ns_neg ? NS_NEG_OFFSET : (borrow ? NS_PER_SEC : 31'd0);

  always_comb begin
    if (diff0_q) begin
      ns1_d  = 31'(hn0_q) + ns_ofs - 31'(ln0_q);
      sec1_d = 34'(hs0_q) - 34'(ls0_q) - 34'(borrow);
    end else begin
      ns1_d  = 31'(hn0_q) + 31'(ln0_q);
      sec1_d = 34'(hs0_q) + 34'(ls0_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      ns1_q  <= ns1_d;
      sec1_q <= sec1_d;
      neg1_q <= ns_neg;
    end
  end

  // stage 2: reduce nanoseconds and carry whole seconds
  logic [29:0] rn2_d, rn2_q;
  logic [34:0] full2_d, full2_q;

  always_comb begin
    if (neg1_q) begin
      rn2_d   = ns1_q[29:0];
      full2_d = 35'(sec1_q) + NS_NEG_CARRY;
    end else if (ns1_q >= NS_TWO_SEC) begin
      rn2_d   = 30'(ns1_q - NS_TWO_SEC);
      full2_d = 35'(sec1_q) + 35'd2;
    end else if (ns1_q >= NS_PER_SEC) begin
      rn2_d   = 30'(ns1_q - NS_PER_SEC);
      full2_d = 35'(sec1_q) + 35'd1;
    end else begin
      rn2_d   = ns1_q[29:0];
      full2_d = 35'(sec1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      rn2_q   <= rn2_d;
      full2_q <= full2_d;
    end
  end

  // stage 3: wrap seconds and flag overflow, then delay to the output stage
  arith_res_t res3_d;
  arith_res_t res_q [3:LAST];

  assign res3_d.seconds  = full2_q[31:0] & SEC_MAX[31:0];
  assign res3_d.nanos    = rn2_q;
  assign res3_d.overflow = (64'(full2_q) > SEC_MAX);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      res_q[3] <= res3_d;
    end
    for (int k = 4; k < LAST; k++) begin
      if (stage_en_i[k]) begin
        res_q[k] <= res_q[k-1];
      end
    end
    if (stage_en_i[LAST]) begin
      res_q[LAST] <= mine_q[LAST-1] ? res_q[LAST-1] : '0;
    end
  end

  // ownership flag travels with the item
  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      mine_q[0] <= is_mine;
    end
    for (int k = 1; k < LAST; k++) begin
      if (stage_en_i[k]) begin
        mine_q[k] <= mine_q[k-1];
      end
    end
  end

  assign res_o = res_q[LAST];

endmodule

### src/dads_split.sv
// split of seconds into 364-day years, days, hours, minutes and seconds
module dads_split import dads_pkg::*; #(
  parameter int SEC_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] stage_en_i,
  input  logic [1:0]            kind_i,
  input  logic [31:0]           a_seconds_i,
  output split_res_t            res_o
);

  localparam logic [63:0] SEC_MAX = (64'd1 << SEC_WIDTH) - 64'd1;
  localparam logic [31:0] IN_MASK = SEC_MAX[31:0];
  localparam int          LAST    = NUM_STAGES - 1;

  logic [LAST-1:0] mine_q;

  // stage 0: year quotient by reciprocal multiply
  logic [31:0] a_s;
  logic [64:0] year_prod;
  logic [31:0] as0_q;
  logic [7:0]  y0_q;

  assign a_s       = a_seconds_i & IN_MASK;
  assign year_prod = 65'(a_s) * 65'(YEAR_RECIP);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      as0_q <= a_s;
      y0_q  <= year_prod[YEAR_SHIFT +: 8];
    end
  end

  // stage 1: seconds left in the year
  logic [32:0] year_rem;
  logic [24:0] r1_q;
  logic [7:0]  y1_q;

  assign year_rem = 33'(as0_q) - 33'(y0_q) * 33'(SEC_PER_YEAR);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      r1_q <= year_rem[24:0];
      y1_q <= y0_q;
    end
  end

  // stage 2: day quotient
  logic [50:0] day_prod;
  logic [24:0] r2_q;
  logic [7:0]  y2_q;
  logic [8:0]  d2_q;

  assign day_prod = 51'(r1_q) * 51'(DAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      r2_q <= r1_q;
      y2_q <= y1_q;
      d2_q <= day_prod[DAY_SHIFT +: 9];
    end
  end

  // stage 3: seconds left in the day
  logic [24:0] day_rem;
  logic [16:0] r3_q;
  logic [7:0]  y3_q;
  logic [8:0]  d3_q;

  assign day_rem = r2_q - 25'(d2_q) * 25'(SEC_PER_DAY);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      r3_q <= day_rem[16:0];
      y3_q <= y2_q;
      d3_q <= d2_q;
    end
  end

  // stage 4: hour quotient
  logic [34:0] hour_prod;
  logic [16:0] r4_q;
  logic [7:0]  y4_q;
  logic [8:0]  d4_q;
  logic [4:0]  h4_q;

  assign hour_prod = 35'(r3_q) * 35'(HOUR_RECIP);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      r4_q <= r3_q;
      y4_q <= y3_q;
      d4_q <= d3_q;
      h4_q <= hour_prod[HOUR_SHIFT +: 5];
    end
  end

  // stage 5: seconds left in the hour
  logic [16:0] hour_rem;
  logic [11:0] r5_q;
  logic [7:0]  y5_q;
  logic [8:0]  d5_q;
  logic [4:0]  h5_q;

  assign hour_rem = r4_q - 17'(h4_q) * 17'(SEC_PER_HOUR);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[5]) begin
      r5_q <= hour_rem[11:0];
      y5_q <= y4_q;
      d5_q <= d4_q;
      h5_q <= h4_q;
    end
  end

  // stage 6: minute quotient
  logic [24:0] min_prod;
  logic [11:0] r6_q;
  logic [7:0]  y6_q;
  logic [8:0]  d6_q;
  logic [4:0]  h6_q;
  logic [5:0]  m6_q;

  assign min_prod = 25'(r5_q) * 25'(MIN_RECIP);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[6]) begin
      r6_q <= r5_q;
      y6_q <= y5_q;
      d6_q <= d5_q;
      h6_q <= h5_q;
      m6_q <= min_prod[MIN_SHIFT +: 6];
    end
  end

  // stage 7: leftover seconds and output register
  logic [11:0] min_rem;
  split_res_t  res7_d, res_q;

  assign min_rem = r6_q - 12'(m6_q) * 12'(SEC_PER_MIN);

  assign res7_d.years   = y6_q;
  assign res7_d.days    = d6_q;
  assign res7_d.hours   = h6_q;
  assign res7_d.minutes = m6_q;
  assign res7_d.seconds = min_rem[5:0];

  always_ff @(posedge clk_i) begin
    if (stage_en_i[LAST]) begin
      res_q <= mine_q[LAST-1] ? res7_d : '0;
    end
  end

  // ownership flag travels with the item
  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      mine_q[0] <= (kind_i == KIND_SPLIT);
    end
    for (int k = 1; k < LAST; k++) begin
      if (stage_en_i[k]) begin
        mine_q[k] <= mine_q[k-1];
      end
    end
  end

  assign res_o = res_q;

endmodule

### src/duration_add_diff_split_core.sv
// top level of the duration add / difference / split pipeline
//
// Input stream: one transfer carries two durations (seconds plus nanoseconds)
// in tdata and the operation code in tuser: add, absolute difference, or
// split of the first operand's seconds into 364-day years, days, hours,
// minutes and seconds. Output stream: one transfer per input transfer, in
// order, with the add/difference fields and the split fields in tdata and
// the seconds overflow flag in tuser; fields of the other operation are zero.
// The pipeline has eight register stages. The depth is set by the chain of
// four constant divisions, each a reciprocal multiply stage followed by a
// multiply-back stage. Throughput is one transfer per clock while the
// receiver keeps taking results.
// Every stage has its own valid bit and advances when the stage after it
// is empty or advancing, so bubbles close up and the input keeps taking
// transfers while the output register holds a result. When the receiver
// stalls the pipe fills and s_axis_tready drops after the stages are full.
// Reset clears all valid bits; data registers are not reset.
module duration_add_diff_split_core import dads_pkg::*; #(
  parameter int SEC_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_seconds, a_nanos, b_seconds, b_nanos, zero pad
  input  logic [127:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_seconds, res_nanos, years, days, hours, minutes, leftover_seconds
  output logic [95:0]  m_axis_tdata,
  // overflow
  output logic         m_axis_tuser
);

  localparam int LAST = NUM_STAGES - 1;

  // per-stage valid bits and ready chain
  logic [NUM_STAGES-1:0] vld_q, vld_d, stage_en;

  always_comb begin
    stage_en[LAST] = !vld_q[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (stage_en[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = stage_en[0];
  assign m_axis_tvalid = vld_q[LAST];

  // datapaths
  arith_res_t arith_res;
  split_res_t split_res;

  dads_arith #(
    .SEC_WIDTH (SEC_WIDTH)
  ) u_arith (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en),
    .kind_i      (s_axis_tuser),
    .a_seconds_i (s_axis_tdata[31:0]),
    .a_nanos_i   (s_axis_tdata[61:32]),
    .b_seconds_i (s_axis_tdata[93:62]),
    .b_nanos_i   (s_axis_tdata[123:94]),
    .res_o       (arith_res)
  );

  dads_split #(
    .SEC_WIDTH (SEC_WIDTH)
  ) u_split (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en),
    .kind_i      (s_axis_tuser),
    .a_seconds_i (s_axis_tdata[31:0]),
    .res_o       (split_res)
  );

  // output packing
  assign m_axis_tdata = {split_res.seconds, split_res.minutes, split_res.hours,
                         split_res.days, split_res.years,
                         arith_res.nanos, arith_res.seconds};
  assign m_axis_tuser = arith_res.overflow;

endmodule

### test/tb_top.sv
// self-checking testbench for the duration add / difference / split pipeline
module tb_top;
  import dads_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 3 * NUM_STAGES;
  localparam int unsigned ITEMS_PER_PHASE = 550;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam logic [63:0] BILLION = 64'd1000000000;
  localparam logic [63:0] YEAR_SECS = 64'd31449600;
  localparam logic [63:0] DAY_SECS = 64'd86400;
  localparam logic [63:0] HOUR_SECS = 64'd3600;
  localparam logic [63:0] MIN_SECS = 64'd60;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // one output transfer, unpacked
  typedef struct packed {
    logic [31:0] res_seconds;
    logic [29:0] res_nanos;
    logic        overflow;
    logic [7:0]  years;
    logic [8:0]  days;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  leftover_seconds;
  } dur_result_t;

  // expected durations in order, compared against the output stream
  class dur_scoreboard;
    dur_result_t pending_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // sum, absolute difference or calendar split of one input transfer
    function dur_result_t calc_duration(logic [1:0] kind, logic [31:0] a_sec,
                                        logic [29:0] a_ns, logic [31:0] b_sec,
                                        logic [29:0] b_ns);
      dur_result_t r;
      logic [63:0] hi_sec, lo_sec, hi_ns, lo_ns, ns, full, rem;
      r = '0;
      case (kind)
        KIND_ADD: begin
          ns = 64'(a_ns) + 64'(b_ns);
          full = 64'(a_sec) + 64'(b_sec) + ns / BILLION;
          r.res_nanos = 30'(ns % BILLION);
          r.overflow = (full > 64'hFFFF_FFFF);
          r.res_seconds = full[31:0];
        end
        KIND_DIFF: begin
          // larger operand first, ordered by seconds then nanoseconds
          if (a_sec > b_sec || (a_sec == b_sec && a_ns > b_ns)) begin
            hi_sec = 64'(a_sec); hi_ns = 64'(a_ns);
            lo_sec = 64'(b_sec); lo_ns = 64'(b_ns);
          end else begin
            hi_sec = 64'(b_sec); hi_ns = 64'(b_ns);
            lo_sec = 64'(a_sec); lo_ns = 64'(a_ns);
          end
          // borrow one second
          if (hi_ns < lo_ns) begin
            hi_ns = hi_ns + BILLION;
            hi_sec = hi_sec - 64'd1;
          end
          ns = hi_ns - lo_ns;
          full = (hi_sec - lo_sec) + ns / BILLION;
          r.res_nanos = 30'(ns % BILLION);
          r.overflow = (full > 64'hFFFF_FFFF);
          r.res_seconds = full[31:0];
        end
        KIND_SPLIT: begin
          rem = 64'(a_sec);
          full = rem / YEAR_SECS;
          r.years = (full > 64'd255) ? 8'hFF : full[7:0];
          rem = rem % YEAR_SECS;
          r.days = 9'(rem / DAY_SECS);
          rem = rem % DAY_SECS;
          r.hours = 5'(rem / HOUR_SECS);
          rem = rem % HOUR_SECS;
          r.minutes = 6'(rem / MIN_SECS);
          r.leftover_seconds = 6'(rem % MIN_SECS);
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_input(logic [1:0] kind, logic [31:0] a_sec, logic [29:0] a_ns,
                             logic [31:0] b_sec, logic [29:0] b_ns);
      pending_q.push_back(calc_duration(kind, a_sec, a_ns, b_sec, b_ns));
    endfunction

    function int pending_count();
      return pending_q.size();
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
    endfunction

    // compare one output transfer against the oldest expectation
    function void check_result(logic [95:0] data, logic ovf);
      dur_result_t exp_r, act_r;
      act_r.res_seconds = data[31:0];
      act_r.res_nanos = data[61:32];
      act_r.years = data[69:62];
      act_r.days = data[78:70];
      act_r.hours = data[83:79];
      act_r.minutes = data[89:84];
      act_r.leftover_seconds = data[95:90];
      act_r.overflow = ovf;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected output transfer, tdata %h tuser %b", data, ovf);
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r.res_seconds !== act_r.res_seconds)
        flag("res_seconds", exp_r.res_seconds, act_r.res_seconds);
      if (exp_r.res_nanos !== act_r.res_nanos)
        flag("res_nanos", 32'(exp_r.res_nanos), 32'(act_r.res_nanos));
      if (exp_r.overflow !== act_r.overflow)
        flag("overflow", 32'(exp_r.overflow), 32'(act_r.overflow));
      if (exp_r.years !== act_r.years)
        flag("years", 32'(exp_r.years), 32'(act_r.years));
      if (exp_r.days !== act_r.days)
        flag("days", 32'(exp_r.days), 32'(act_r.days));
      if (exp_r.hours !== act_r.hours)
        flag("hours", 32'(exp_r.hours), 32'(act_r.hours));
      if (exp_r.minutes !== act_r.minutes)
        flag("minutes", 32'(exp_r.minutes), 32'(act_r.minutes));
      if (exp_r.leftover_seconds !== act_r.leftover_seconds)
        flag("leftover_seconds", 32'(exp_r.leftover_seconds),
             32'(act_r.leftover_seconds));
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // a_seconds, a_nanos, b_seconds, b_nanos, zero pad
  logic [127:0] s_axis_tdata = '0;
  // kind
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // res_seconds, res_nanos, years, days, hours, minutes, leftover_seconds
  logic [95:0]  m_axis_tdata;
  // overflow
  logic         m_axis_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned phase = 0;
  int unsigned cycle_count = 0;

  dur_scoreboard sb = new();

  duration_add_diff_split_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever begin
      #6 clk_i = 1'b1;
      #6 clk_i = 1'b0;
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // offer one operation, called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [1:0] kind, input logic [31:0] a_sec,
                           input logic [29:0] a_ns, input logic [31:0] b_sec,
                           input logic [29:0] b_ns);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, b_ns, b_sec, a_ns, a_sec};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(kind, a_sec, a_ns, b_sec, b_ns);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_seconds();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 1000));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      3: return 32'($urandom_range(0, 200000000));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [29:0] rand_nanos();
    case ($urandom_range(0, 7))
      0: return 30'd999999999 - 30'($urandom_range(0, 1000));
      1: return 30'($urandom_range(0, 1000));
      2: return 30'($urandom());
      default: return 30'($urandom_range(0, 999999999));
    endcase
  endfunction

  // receiver: random back-pressure plus one long hold at the start of phase 3
  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase == 3 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // output transfer check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // stimulus
  initial begin
    logic [1:0]  kind;
    logic [31:0] a_sec, b_sec;
    logic [29:0] a_ns, b_ns;
    int unsigned pick;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    phase = 1;
    send_idle_pct = 33;
    recv_idle_pct = 80;

    // add: zero, double carry with wrap, unnormalized carry of two, carry into wrap
    send_item(KIND_ADD, 32'd0, 30'd0, 32'd0, 30'd0);
    send_item(KIND_ADD, 32'hFFFF_FFFF, 30'd999999999, 32'hFFFF_FFFF, 30'd999999999);
    send_item(KIND_ADD, 32'd7, 30'h3FFF_FFFF, 32'd9, 30'h3FFF_FFFF);
    send_item(KIND_ADD, 32'hFFFF_FFFF, 30'd500000000, 32'd0, 30'd500000000);
    // difference: equal, borrow, swapped order, tie on seconds both ways
    send_item(KIND_DIFF, 32'd12345, 30'd678, 32'd12345, 30'd678);
    send_item(KIND_DIFF, 32'd100, 30'd10, 32'd40, 30'd999999999);
    send_item(KIND_DIFF, 32'd40, 30'd999999999, 32'd100, 30'd10);
    send_item(KIND_DIFF, 32'd55, 30'd900000000, 32'd55, 30'd100000000);
    send_item(KIND_DIFF, 32'd55, 30'd100000000, 32'd55, 30'd900000000);
    send_item(KIND_DIFF, 32'hFFFF_FFFF, 30'd0, 32'd0, 30'd0);
    // difference: unnormalized nanoseconds carry, and carry past the seconds range
    send_item(KIND_DIFF, 32'd5, 30'h3FFF_FFFF, 32'd0, 30'd0);
    send_item(KIND_DIFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'd0, 30'd0);
    // split: range ends and unit boundaries
    send_item(KIND_SPLIT, 32'd0, 30'd0, 32'd0, 30'd0);
    send_item(KIND_SPLIT, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
    send_item(KIND_SPLIT, 32'd31449599, 30'd5, 32'd1, 30'd1);
    send_item(KIND_SPLIT, 32'd31449600, 30'd0, 32'd0, 30'd0);
    send_item(KIND_SPLIT, 32'd86399, 30'd0, 32'd0, 30'd0);
    send_item(KIND_SPLIT, 32'd3599, 30'd0, 32'd0, 30'd0);
    send_item(KIND_SPLIT, 32'd59, 30'd0, 32'd0, 30'd0);
    send_item(KIND_SPLIT, 32'd60, 30'd0, 32'd0, 30'd0);
    // unknown operation gives an all-zero result
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
    send_item(KIND_UNUSED, 32'd1234567, 30'd7654321, 32'd99, 30'd12);

    // random operations over three idle patterns
    for (int p = 1; p <= 3; p++) begin
      phase = p;
      case (p)
        1: begin
          send_idle_pct = 33;
          recv_idle_pct = 80;
        end
        2: begin
          send_idle_pct = 80;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        kind = (pick == 0) ? KIND_UNUSED : 2'((pick - 1) % 3);
        a_sec = rand_seconds();
        b_sec = rand_seconds();
        a_ns = rand_nanos();
        b_ns = rand_nanos();
        // ties on seconds, sometimes on nanoseconds too
        if (kind == KIND_DIFF && $urandom_range(0, 3) == 0) begin
          b_sec = a_sec;
          if ($urandom_range(0, 2) == 0)
            b_ns = a_ns;
        end
        send_item(kind, a_sec, a_ns, b_sec, b_ns);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray output transfers
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
